### rtl/core/bsa_pkg.sv
// shared types, codes and helpers of the bitmap slot allocator
package bsa_pkg;

	localparam int WORD_BITS  = 32;
	localparam int BIDX_W     = 16;
	localparam int CNT_W      = 6;
	localparam int WIDX_W     = BIDX_W - $clog2(WORD_BITS);
	localparam int POS_W      = $clog2(WORD_BITS);
	localparam int FREE_W     = 10;
	localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

	typedef enum logic [2:0] {
		OP_SET    = 3'd0,
		OP_UNSET  = 3'd1,
		OP_GET    = 3'd2,
		OP_SEARCH = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_RANGE  = 2'd1,
		ST_NOFREE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_MODIFY,
		S_SEARCH,
		S_SWEEP
	} state_t;

	typedef struct packed {
		logic [2:0]        op;
		logic [BIDX_W-1:0] bit_index;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              bit_value;
		logic [FREE_W-1:0] free_index;
	} rsp_t;

	typedef struct packed {
		logic                 rd_en;
		logic [WIDX_W-1:0]    rd_addr;
		logic                 wr_en;
		logic [WIDX_W-1:0]    wr_addr;
		logic [WORD_BITS-1:0] wr_data;
	} mem_req_t;

	function automatic logic [POS_W-1:0] first_zero(logic [WORD_BITS-1:0] d);
		logic [POS_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!d[i]) begin
				idx = POS_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

### rtl/core/bitmap_slot_allocator_unit.sv
// bitmap slot allocator top level: sequencer, word memory and result register
//
//  channel  signals                      dir  transfer when
//  req      req_valid req_stall req      in   req_valid && !req_stall
//  rsp      rsp_valid rsp_stall rsp      out  rsp_valid && !rsp_stall
//  cfg      cfg_valid cfg_ready cfg_data in   cfg_valid && cfg_ready
//
//  set, unset, get: accept, memory read, then modify and write back; out of range answers at decode
//  search: reads words from the anchor in order until one holds a zero or words_in_use is reached
//  clear: every word in use is zeroed, one word zeroed per cycle through the write port
//  after reset the first min(32, MAX_WORDS) words are zeroed, one per cycle, before
//  req_stall drops; a count increase zeroes the new words the same way
//  a finished result waits in the rsp register; the next one holds until it is taken
module bitmap_slot_allocator_unit #(
	parameter int MAX_WORDS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  bsa_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output bsa_pkg::rsp_t              rsp,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [bsa_pkg::CNT_W-1:0]  cfg_data
);
	import bsa_pkg::*;

	mem_req_t             mreq;
	logic [WORD_BITS-1:0] rdata;
	logic                 take;
	logic                 done;
	rsp_t                 result;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	assign take = !rsp_valid_q || !rsp_stall;

	bsa_word_mem #(
		.MAX_WORDS(MAX_WORDS)
	) u_mem (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (rdata)
	);

	bsa_seq #(
		.MAX_WORDS(MAX_WORDS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.take      (take),
		.done      (done),
		.result    (result),
		.mreq      (mreq),
		.rdata     (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/core/bsa_word_mem.sv
// bitmap word memory, one write port and one registered read port
module bsa_word_mem #(
	parameter int MAX_WORDS = 32
) (
	input  logic                           clk,
	input  bsa_pkg::mem_req_t              mreq,
	output logic [bsa_pkg::WORD_BITS-1:0]  rdata
);
	import bsa_pkg::*;

	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

	logic [WORD_BITS-1:0] mem_q [MAX_WORDS];
	logic [WORD_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			mem_q[mreq.wr_addr[AW-1:0]] <= mreq.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mreq.rd_en) begin
			rdata_q <= mem_q[mreq.rd_addr[AW-1:0]];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/bsa_seq.sv
// sequencer: op decode, read-modify-write, word scan, clearing sweeps, anchor and count
module bsa_seq #(
	parameter int MAX_WORDS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  bsa_pkg::req_t                  req,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bsa_pkg::CNT_W-1:0]      cfg_data,
	input  logic                           take,
	output logic                           done,
	output bsa_pkg::rsp_t                  result,
	output bsa_pkg::mem_req_t              mreq,
	input  logic [bsa_pkg::WORD_BITS-1:0]  rdata
);
	import bsa_pkg::*;

	localparam int CNT_MAX = (MAX_WORDS < 63) ? MAX_WORDS : 63;
	localparam int RST_CNT = (MAX_WORDS < 32) ? MAX_WORDS : 32;

	state_t             state_q, state_d;
	logic [2:0]         op_q, op_d;
	logic [BIDX_W-1:0]  bidx_q, bidx_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   anchor_q, anchor_d;
	logic [CNT_W-1:0]   ptr_q, ptr_d;
	logic [CNT_W-1:0]   hi_q, hi_d;
	logic               sweep_rsp_q, sweep_rsp_d;
	logic [CNT_W-1:0]   addr_s1, addr_s1_d;

	logic [WIDX_W-1:0]    widx;
	logic                 in_range;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] new_word;
	logic [CNT_W-1:0]     cfg_cnt;

	assign widx     = bidx_q[BIDX_W-1:POS_W];
	assign in_range = widx < WIDX_W'(count_q);
	assign mask     = WORD_BITS'(1) << bidx_q[POS_W-1:0];
	assign cfg_cnt  = (cfg_data > CNT_W'(CNT_MAX)) ? CNT_W'(CNT_MAX) : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= CNT_W'(RST_CNT);
			anchor_q    <= '0;
			ptr_q       <= '0;
			hi_q        <= CNT_W'(RST_CNT);
			sweep_rsp_q <= 1'b0;
		end else begin
			count_q     <= count_d;
			anchor_q    <= anchor_d;
			ptr_q       <= ptr_d;
			hi_q        <= hi_d;
			sweep_rsp_q <= sweep_rsp_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q    <= op_d;
		bidx_q  <= bidx_d;
		addr_s1 <= addr_s1_d;
	end

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		bidx_d      = bidx_q;
		count_d     = count_q;
		anchor_d    = anchor_q;
		ptr_d       = ptr_q;
		hi_d        = hi_q;
		sweep_rsp_d = sweep_rsp_q;
		addr_s1_d   = addr_s1;
		req_stall   = 1'b1;
		cfg_ready   = 1'b0;
		done        = 1'b0;
		result      = '0;
		mreq        = '0;
		new_word    = '0;

		case (state_q)
			S_IDLE: begin
				cfg_ready = 1'b1;
				req_stall = cfg_valid;
				if (cfg_valid) begin
					count_d = cfg_cnt;
					if (cfg_cnt > count_q) begin
						ptr_d       = count_q;
						hi_d        = cfg_cnt;
						sweep_rsp_d = 1'b0;
						state_d     = S_SWEEP;
					end
				end else if (req_valid) begin
					op_d    = req.op;
					bidx_d  = req.bit_index;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (op_q)
					OP_SET, OP_UNSET, OP_GET: begin
						if (!in_range) begin
							if (take) begin
								done          = 1'b1;
								result.status = ST_RANGE;
								state_d       = S_IDLE;
							end
						end else begin
							mreq.rd_en   = 1'b1;
							mreq.rd_addr = widx;
							state_d      = S_MODIFY;
						end
					end
					OP_SEARCH: begin
						if (anchor_q < count_q) begin
							mreq.rd_en   = 1'b1;
							mreq.rd_addr = WIDX_W'(anchor_q);
							addr_s1_d    = anchor_q;
							ptr_d        = anchor_q + CNT_W'(1);
							state_d      = S_SEARCH;
						end else if (take) begin
							done          = 1'b1;
							result.status = ST_NOFREE;
							state_d       = S_IDLE;
						end
					end
					OP_CLEAR: begin
						ptr_d       = '0;
						hi_d        = count_q;
						sweep_rsp_d = 1'b1;
						state_d     = S_SWEEP;
					end
					default: begin
						if (take) begin
							done    = 1'b1;
							state_d = S_IDLE;
						end
					end
				endcase
			end
			S_MODIFY: begin
				if (take) begin
					done    = 1'b1;
					state_d = S_IDLE;
					case (op_q)
						OP_SET: begin
							new_word     = rdata | mask;
							mreq.wr_en   = 1'b1;
							mreq.wr_addr = widx;
							mreq.wr_data = new_word;
							if (widx == WIDX_W'(anchor_q) && new_word == FULL_WORD) begin
								anchor_d = anchor_q + CNT_W'(1);
							end
						end
						OP_UNSET: begin
							new_word     = rdata & ~mask;
							mreq.wr_en   = 1'b1;
							mreq.wr_addr = widx;
							mreq.wr_data = new_word;
							if (widx <= WIDX_W'(anchor_q)) begin
								anchor_d = widx[CNT_W-1:0];
							end
						end
						OP_GET: begin
							result.bit_value = |(rdata & mask);
						end
						default: begin
						end
					endcase
				end
			end
			S_SEARCH: begin
				if (rdata != FULL_WORD) begin
					if (take) begin
						done              = 1'b1;
						result.free_index = FREE_W'({addr_s1, first_zero(rdata)});
						anchor_d          = addr_s1;
						state_d           = S_IDLE;
					end
				end else if (ptr_q < count_q) begin
					mreq.rd_en   = 1'b1;
					mreq.rd_addr = WIDX_W'(ptr_q);
					addr_s1_d    = ptr_q;
					ptr_d        = ptr_q + CNT_W'(1);
				end else if (take) begin
					done          = 1'b1;
					result.status = ST_NOFREE;
					state_d       = S_IDLE;
				end
			end
			S_SWEEP: begin
				if (ptr_q < hi_q) begin
					mreq.wr_en   = 1'b1;
					mreq.wr_addr = WIDX_W'(ptr_q);
					mreq.wr_data = '0;
					ptr_d        = ptr_q + CNT_W'(1);
				end else if (!sweep_rsp_q) begin
					state_d = S_IDLE;
				end else if (take) begin
					done    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### tb/tb_top.sv
// testbench for the bitmap slot allocator: random and directed ops checked against a bitmap predictor
`timescale 1ns / 100ps

module tb_top;
	import bsa_pkg::*;

	localparam int NUM_WORDS = 32;
	localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
	localparam logic [2:0] OP_RSVD_LAST = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;

	logic [WORD_BITS-1:0] occ_words [NUM_WORDS];
	int anchor;
	int words_used;
	rsp_t pending_results [$];
	rsp_t last_pred;
	int fail_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int stall_hold = 0;

	bitmap_slot_allocator_unit #(.MAX_WORDS(NUM_WORDS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic rsp_t bitmap_apply(logic [2:0] op, logic [BIDX_W-1:0] bidx);
		rsp_t r;
		int w;
		int p;
		int i;
		int j;
		bit found;
		r = '0;
		w = int'(bidx) / WORD_BITS;
		p = int'(bidx) % WORD_BITS;
		found = 1'b0;
		case (op)
			OP_SET: begin
				if (w >= words_used) begin
					r.status = ST_RANGE;
				end else begin
					occ_words[w][p] = 1'b1;
					if (w == anchor && occ_words[w] == FULL_WORD) begin
						anchor++;
					end
				end
			end
			OP_UNSET: begin
				if (w >= words_used) begin
					r.status = ST_RANGE;
				end else begin
					occ_words[w][p] = 1'b0;
					if (w <= anchor) begin
						anchor = w;
					end
				end
			end
			OP_GET: begin
				if (w >= words_used) begin
					r.status = ST_RANGE;
				end else begin
					r.bit_value = occ_words[w][p];
				end
			end
			OP_SEARCH: begin
				for (i = anchor; i < words_used && !found; i++) begin
					for (j = 0; j < WORD_BITS && !found; j++) begin
						if (!occ_words[i][j]) begin
							anchor = i;
							r.free_index = FREE_W'(i * WORD_BITS + j);
							found = 1'b1;
						end
					end
				end
				if (!found) begin
					r.status = ST_NOFREE;
				end
			end
			OP_CLEAR: begin
				for (i = 0; i < words_used; i++) begin
					occ_words[i] = '0;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic void count_apply(logic [CNT_W-1:0] v);
		int n;
		int i;
		n = (int'(v) > NUM_WORDS) ? NUM_WORDS : int'(v);
		for (i = words_used; i < n; i++) begin
			occ_words[i] = '0;
		end
		words_used = n;
	endfunction

	function automatic logic [BIDX_W-1:0] rand_in_range();
		if (words_used == 0) begin
			return BIDX_W'($urandom_range(65535));
		end
		return BIDX_W'($urandom_range(words_used * WORD_BITS - 1));
	endfunction

	task automatic note_fail(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	task automatic send_req(input logic [2:0] op, input logic [BIDX_W-1:0] bidx);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req.op = op;
		req.bit_index = bidx;
		req_valid = 1'b1;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		last_pred = bitmap_apply(op, bidx);
		pending_results.push_back(last_pred);
	endtask

	task automatic wait_drain();
		@(negedge clk);
		req_valid = 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic set_word_count(input logic [CNT_W-1:0] v);
		wait_drain();
		repeat (40) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		count_apply(v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// receiver: random stall, or a counted hold-off when requested
	always @(negedge clk) begin
		if (stall_hold > 0) begin
			rsp_stall = 1'b1;
			stall_hold--;
		end else begin
			rsp_stall = ($urandom_range(99) < stall_pct);
		end
	end

	// result check on every output transfer
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				note_fail($sformatf("unexpected result: status %0d bit %0d free %0d",
					rsp.status, rsp.bit_value, rsp.free_index));
			end else begin
				exp_rsp = pending_results.pop_front();
				if (rsp.status !== exp_rsp.status || rsp.bit_value !== exp_rsp.bit_value ||
						rsp.free_index !== exp_rsp.free_index) begin
					note_fail($sformatf(
						"mismatch: status %0d/%0d bit %0d/%0d free %0d/%0d (exp/got)",
						exp_rsp.status, rsp.status, exp_rsp.bit_value, rsp.bit_value,
						exp_rsp.free_index, rsp.free_index));
				end
			end
		end
	end

	task automatic test_directed();
		logic [2:0] k;
		send_req(OP_GET, 16'd0);
		send_req(OP_SET, 16'd0);
		send_req(OP_GET, 16'd0);
		send_req(OP_SET, 16'd1023);
		send_req(OP_GET, 16'd1023);
		send_req(OP_GET, 16'd1024);
		send_req(OP_SET, 16'hFFFF);
		send_req(OP_UNSET, 16'hFFFF);
		send_req(OP_GET, 16'hFFFF);
		send_req(OP_SEARCH, 16'hFFFF);
		send_req(OP_UNSET, 16'd0);
		send_req(OP_SEARCH, 16'd0);
		for (k = OP_RSVD_FIRST; k != OP_RSVD_LAST; k++) begin
			send_req(k, 16'hFFFF);
		end
		send_req(OP_RSVD_LAST, 16'hAAAA);
		send_req(OP_CLEAR, 16'hFFFF);
		send_req(OP_GET, 16'd1023);
		send_req(OP_SEARCH, 16'h5555);
	endtask

	task automatic test_config_edges();
		set_word_count(6'd0);
		send_req(OP_SET, 16'd0);
		send_req(OP_GET, 16'd0);
		send_req(OP_UNSET, 16'd0);
		send_req(OP_SEARCH, 16'd0);
		send_req(OP_CLEAR, 16'd0);
		set_word_count(6'd63);
		send_req(OP_GET, 16'd1023);
		send_req(OP_SET, 16'd1023);
		send_req(OP_GET, 16'd1024);
		send_req(OP_SEARCH, 16'd0);
	endtask

	task automatic test_alloc_fill();
		set_word_count(6'd2);
		send_req(OP_CLEAR, 16'd0);
		forever begin
			send_req(OP_SEARCH, BIDX_W'($urandom));
			if (last_pred.status != ST_OK) begin
				break;
			end
			send_req(OP_SET, BIDX_W'(last_pred.free_index));
		end
		send_req(OP_UNSET, 16'd40);
		send_req(OP_UNSET, 16'd3);
		send_req(OP_SEARCH, 16'd0);
		send_req(OP_SET, 16'd3);
		send_req(OP_SEARCH, 16'd0);
		send_req(OP_SET, 16'd40);
		send_req(OP_CLEAR, 16'd0);
		send_req(OP_SEARCH, 16'd0);
		send_req(OP_SET, 16'd33);
		send_req(OP_SET, 16'd63);
		// anchor sits on word two, shrink below it
		set_word_count(6'd1);
		send_req(OP_SEARCH, 16'd0);
		send_req(OP_GET, 16'd33);
		set_word_count(6'd2);
		send_req(OP_GET, 16'd33);
		send_req(OP_GET, 16'd63);
		send_req(OP_SEARCH, 16'd0);
	endtask

	task automatic test_stall_fill();
		int i;
		set_word_count(6'd32);
		send_idle_pct = 0;
		stall_pct = 0;
		@(negedge clk);
		stall_hold = 300;
		for (i = 0; i < 24; i++) begin
			send_req(($urandom_range(1) != 0) ? OP_SET : OP_GET, rand_in_range());
		end
		wait_drain();
	endtask

	task automatic test_random(input int n_items, input logic [CNT_W-1:0] count,
			input int idle_pct, input int stall_pc);
		int sent;
		int pick;
		bit paused;
		set_word_count(count);
		send_idle_pct = idle_pct;
		stall_pct = stall_pc;
		sent = 0;
		paused = 1'b0;
		while (sent < n_items) begin
			if (!paused && sent >= n_items / 2) begin
				wait_drain();
				paused = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 40) begin
				send_req(OP_SEARCH, BIDX_W'($urandom));
				sent++;
				if (last_pred.status == ST_OK && $urandom_range(99) < 85) begin
					send_req(OP_SET, BIDX_W'(last_pred.free_index));
					sent++;
				end
			end else if (pick < 60) begin
				send_req(OP_UNSET, rand_in_range());
				sent++;
			end else if (pick < 72) begin
				send_req(OP_SET, rand_in_range());
				sent++;
			end else if (pick < 85) begin
				send_req(OP_GET, rand_in_range());
				sent++;
			end else if (pick < 93) begin
				send_req(3'($urandom_range(OP_GET)), BIDX_W'($urandom));
				sent++;
			end else if (pick < 97) begin
				send_req(3'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST)), BIDX_W'($urandom));
				sent++;
			end else begin
				send_req(OP_CLEAR, BIDX_W'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		for (int i = 0; i < NUM_WORDS; i++) begin
			occ_words[i] = '0;
		end
		anchor = 0;
		words_used = NUM_WORDS;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_config_edges();
		test_alloc_fill();
		test_stall_fill();
		test_random(300, 6'd32, 0, 0);
		test_random(300, 6'd4, 64, 0);
		test_random(300, 6'd2, 0, 64);
		test_random(300, 6'd17, 20, 20);

		wait_drain();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

### filelist.f
rtl/core/bsa_pkg.sv
rtl/core/bsa_word_mem.sv
rtl/core/bsa_seq.sv
rtl/core/bitmap_slot_allocator_unit.sv
tb/tb_top.sv
